// ===== sv/dclsc_pkg.sv =====
// Package for the dual channel load set-point controller.
// Holds field widths, fixed-point gains and stream widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dclsc_pkg;

	localparam int LEVEL_STEPS_DEF = 120;

	localparam int LEVEL_W = 7;
	localparam int CODE_W  = 8;
	localparam int ADC_W   = 10;
	localparam int ADC_MAX = 1023;
	localparam int DAC_W   = 12;

	localparam logic [DAC_W-1:0] DAC_MAX = 12'hfff;

	localparam int CUR_GAIN = 4914;
	localparam int PWR_GAIN = 25135110;
	localparam int V_SCALE  = 15;

	localparam int NUM_W = 32;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

endpackage

`default_nettype wire

// ===== sv/dual_channel_load_setpoint_controller_unit.sv =====
// Dual channel load set-point controller: command decode, per-channel state
// and a shared restoring divider that turns set levels and ADC readings into DAC codes.
// Depends on dclsc_pkg.
//
// channel | dir | tdata (low bit first)                         | tuser
// s_      | in  | command[7:0] adc_ch0[17:8] adc_ch1[27:18]       | mode
// m_      | out | dac_ch0 dac_ch1 pm0 pm1 level0 level1 sync_on    | dac_update
//
// A command item passes from acceptance through S_HOLD to a result in the output register.
// A sample item passes, per channel, through S_LOAD and up to 13 divider steps in S_DIV
// in the one shared compare/subtract unit, then through S_HOLD to hand over the result.
// s_tready is high only while no item is in work; a stalled result keeps the item in S_HOLD
// and holds off the next item. Reset sets both channels to current mode, level 0, sync off.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_load_setpoint_controller_unit #(
	parameter int LEVEL_STEPS = dclsc_pkg::LEVEL_STEPS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// command[7:0], adc_ch0[17:8], adc_ch1[27:18], zero fill
	input  wire logic [dclsc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// mode
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// dac_ch0[11:0], dac_ch1[23:12], power_mode_ch0[24], power_mode_ch1[25],
	// level_ch0[32:26], level_ch1[39:33], sync_on[40], zero fill
	output logic [dclsc_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// dac_update
	output logic                                    m_tuser
);

	localparam int LEVEL_W  = dclsc_pkg::LEVEL_W;
	localparam int CODE_W   = dclsc_pkg::CODE_W;
	localparam int ADC_W    = dclsc_pkg::ADC_W;
	localparam int DAC_W    = dclsc_pkg::DAC_W;
	localparam int NUM_W    = dclsc_pkg::NUM_W;
	localparam int DEN_GAIN = LEVEL_STEPS * dclsc_pkg::V_SCALE;
	localparam int DEN_W    = $clog2(DEN_GAIN * dclsc_pkg::ADC_MAX + 1);
	localparam int DSH_W    = DEN_W + DAC_W;
	localparam int CMP_W    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int CNT_W    = $clog2(DAC_W + 1);
	localparam int PAD_W    = dclsc_pkg::OUT_TDATA_W - 2 * DAC_W - 2 - 2 * LEVEL_W - 1;

	localparam logic [CODE_W-1:0] CODE_ZERO     = '0;
	localparam logic [CODE_W-1:0] CODE_STEPS    = CODE_W'(LEVEL_STEPS);
	localparam logic [CODE_W-1:0] CODE_POWER    = CODE_W'(LEVEL_STEPS + 1);
	localparam logic [CODE_W-1:0] CODE_CURRENT  = CODE_W'(LEVEL_STEPS + 3);
	localparam logic [CODE_W-1:0] CODE_SYNC_ON  = CODE_W'(LEVEL_STEPS + 5);
	localparam logic [CODE_W-1:0] CODE_SYNC_OFF = CODE_W'(LEVEL_STEPS + 7);

	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(DAC_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_HOLD
	} state_t;

	state_t                        state_q;
	logic                          pm_q    [2];
	logic [LEVEL_W-1:0]            level_q [2];
	logic                          sync_q;
	logic [ADC_W-1:0]              adc_q   [2];
	logic [DAC_W-1:0]              dac_q   [2];
	logic                          upd_q;
	logic                          ch_q;
	logic [NUM_W-1:0]              rem_q;
	logic [DSH_W-1:0]              dsh_q;
	logic [DAC_W-1:0]              quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          m_tvalid_q;
	logic [dclsc_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                          m_tuser_q;

	logic                          nxt_pm    [2];
	logic [LEVEL_W-1:0]            nxt_level [2];
	logic                          nxt_sync;
	logic [CODE_W-1:0]             code;
	logic                          ch_sel;
	logic                          hit;

	logic [LEVEL_W-1:0]            lvl_sel;
	logic                          pm_sel;
	logic [ADC_W-1:0]              adc_sel;
	logic [NUM_W-1:0]              gain_sel;
	logic [NUM_W-1:0]              num_load;
	logic [DEN_W-1:0]              den_load;
	logic                          ge;
	logic [DAC_W-1:0]              quo_next;
	logic                          accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		code     = {1'b0, s_tdata[CODE_W-2:0]};
		ch_sel   = s_tdata[CODE_W-1];
		nxt_sync = sync_q;
		hit      = 1'b0;
		if (code == CODE_SYNC_ON) begin
			nxt_sync = 1'b1;
		end else if (code == CODE_SYNC_OFF) begin
			nxt_sync = 1'b0;
		end
		for (int c = 0; c < 2; c++) begin
			nxt_pm[c]    = pm_q[c];
			nxt_level[c] = level_q[c];
			hit = (ch_sel == 1'(c)) || sync_q;
			if (hit && code != CODE_SYNC_ON && code != CODE_SYNC_OFF) begin
				if (code != CODE_ZERO && code < CODE_STEPS) begin
					nxt_level[c] = code[LEVEL_W-1:0];
				end else if (code == CODE_POWER) begin
					nxt_pm[c]    = 1'b1;
					nxt_level[c] = '0;
				end else if (code == CODE_CURRENT) begin
					nxt_pm[c]    = 1'b0;
					nxt_level[c] = '0;
				end else if (code == CODE_ZERO) begin
					nxt_level[c] = '0;
				end
			end
		end
	end

	always_comb begin
		lvl_sel  = level_q[ch_q];
		pm_sel   = pm_q[ch_q];
		adc_sel  = adc_q[ch_q];
		gain_sel = pm_sel ? NUM_W'(dclsc_pkg::PWR_GAIN) : NUM_W'(dclsc_pkg::CUR_GAIN);
		num_load = NUM_W'(NUM_W'(lvl_sel) * gain_sel);
		den_load = pm_sel ? DEN_W'(DEN_W'(DEN_GAIN) * DEN_W'(adc_sel))
		                  : DEN_W'(LEVEL_STEPS);
		ge       = CMP_W'(rem_q) >= CMP_W'(dsh_q);
		quo_next = {quo_q[DAC_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pm_q[0]    <= 1'b0;
			pm_q[1]    <= 1'b0;
			level_q[0] <= '0;
			level_q[1] <= '0;
			sync_q     <= 1'b0;
			adc_q[0]   <= '0;
			adc_q[1]   <= '0;
			dac_q[0]   <= '0;
			dac_q[1]   <= '0;
			upd_q      <= 1'b0;
			ch_q       <= 1'b0;
			rem_q      <= '0;
			dsh_q      <= '0;
			quo_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tready && state_q != S_HOLD) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						adc_q[0] <= s_tdata[CODE_W +: ADC_W];
						adc_q[1] <= s_tdata[CODE_W + ADC_W +: ADC_W];
						upd_q    <= s_tuser;
						ch_q     <= 1'b0;
						dac_q[0] <= '0;
						dac_q[1] <= '0;
						if (s_tuser) begin
							state_q <= S_LOAD;
						end else begin
							pm_q[0]    <= nxt_pm[0];
							pm_q[1]    <= nxt_pm[1];
							level_q[0] <= nxt_level[0];
							level_q[1] <= nxt_level[1];
							sync_q     <= nxt_sync;
							state_q    <= S_HOLD;
						end
					end
				end
				S_LOAD: begin
					if (pm_sel && lvl_sel == '0) begin
						dac_q[ch_q] <= '0;
						ch_q        <= 1'b1;
						state_q     <= ch_q ? S_HOLD : S_LOAD;
					end else if (pm_sel && adc_sel == '0) begin
						dac_q[ch_q] <= dclsc_pkg::DAC_MAX;
						ch_q        <= 1'b1;
						state_q     <= ch_q ? S_HOLD : S_LOAD;
					end else begin
						rem_q   <= num_load;
						dsh_q   <= {den_load, DAC_W'(0)};
						quo_q   <= '0;
						cnt_q   <= CNT_SAT;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_SAT && ge) begin
						dac_q[ch_q] <= dclsc_pkg::DAC_MAX;
						ch_q        <= 1'b1;
						state_q     <= ch_q ? S_HOLD : S_LOAD;
					end else begin
						if (ge) begin
							rem_q <= rem_q - NUM_W'(dsh_q);
						end
						dsh_q <= dsh_q >> 1;
						quo_q <= quo_next;
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == '0) begin
							dac_q[ch_q] <= quo_next;
							ch_q        <= 1'b1;
							state_q     <= ch_q ? S_HOLD : S_LOAD;
						end
					end
				end
				S_HOLD: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= upd_q;
						m_tdata_q  <= {PAD_W'(0), sync_q, level_q[1], level_q[0],
						               pm_q[1], pm_q[0], dac_q[1], dac_q[0]};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_sample_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> state_q == S_LOAD)
		else $error("sample transaction did not start the divider");

	a_cmd_zero_dac: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[2*DAC_W-1:0] == '0)
		else $error("command result carries nonzero DAC codes");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q[0] < CODE_STEPS[LEVEL_W-1:0] && level_q[1] < CODE_STEPS[LEVEL_W-1:0])
		else $error("set level out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dsh_q != '0)
		else $error("divider running with zero divisor");

	a_state_frozen_in_sample: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |=> $stable(level_q[0]) && $stable(level_q[1]) && $stable(sync_q))
		else $error("channel state changed during a sample");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for dual_channel_load_setpoint_controller_unit: directed and
// random command and sample transactions are checked against typed-in results or a built-in set-point predictor.
// Depends on dclsc_pkg and the controller RTL.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

	localparam int unsigned STEPS = dclsc_pkg::LEVEL_STEPS_DEF;

	localparam logic [6:0] CODE_ZERO     = 7'd0;
	localparam logic [6:0] CODE_SPARE0   = 7'(STEPS);
	localparam logic [6:0] CODE_POWER    = 7'(STEPS + 1);
	localparam logic [6:0] CODE_SPARE2   = 7'(STEPS + 2);
	localparam logic [6:0] CODE_CURRENT  = 7'(STEPS + 3);
	localparam logic [6:0] CODE_SPARE4   = 7'(STEPS + 4);
	localparam logic [6:0] CODE_SYNC_ON  = 7'(STEPS + 5);
	localparam logic [6:0] CODE_SPARE6   = 7'(STEPS + 6);
	localparam logic [6:0] CODE_SYNC_OFF = 7'(STEPS + 7);
	localparam logic [7:0] SEL_CH1       = 8'h80;

	localparam int N_DIRECTED   = 25;
	localparam int N_RANDOM     = 700;
	localparam int QUIET_FROM   = 600;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic        upd;
		logic [11:0] dac0;
		logic [11:0] dac1;
		logic        pm0;
		logic        pm1;
		logic [6:0]  lvl0;
		logic [6:0]  lvl1;
		logic        sync;
	} setpoint_result_t;

	typedef struct packed {
		logic             sample;
		logic [7:0]       cmd;
		logic [9:0]       adc0;
		logic [9:0]       adc1;
		logic             typed;
		setpoint_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [dclsc_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [dclsc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic        m_tuser;

	dual_channel_load_setpoint_controller_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic             ld_power [2];
	logic [6:0]       ld_level [2];
	logic             ld_sync;
	setpoint_result_t expected_q [$];
	stim_row_t        directed_rows [N_DIRECTED];
	int               errors;
	int               cycle_count;
	int               n_cmd;
	int               n_sample;
	int               n_power_drive;
	bit               quiet;

	task automatic report_error(string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("ERROR @%0d: %s", cycle_count, msg);
	endtask

	function automatic logic [11:0] drive_dac(int ch, logic [9:0] adc);
		longint unsigned lvl;
		longint unsigned q;
		lvl = ld_level[ch];
		if (ld_power[ch]) begin
			if (lvl == 0)
				return 12'd0;
			if (adc == 0)
				return dclsc_pkg::DAC_MAX;
			q = (lvl * longint'(dclsc_pkg::PWR_GAIN)) /
				(longint'(STEPS) * longint'(dclsc_pkg::V_SCALE) * longint'(adc));
		end else begin
			q = (lvl * longint'(dclsc_pkg::CUR_GAIN)) / longint'(STEPS);
		end
		return (q > longint'(dclsc_pkg::DAC_MAX)) ? dclsc_pkg::DAC_MAX : q[11:0];
	endfunction

	function automatic void apply_code(int ch, logic [6:0] code);
		if (code > 0 && code < STEPS) begin
			ld_level[ch] = code;
		end else if (code == CODE_POWER) begin
			ld_power[ch] = 1'b1;
			ld_level[ch] = 7'd0;
		end else if (code == CODE_CURRENT) begin
			ld_power[ch] = 1'b0;
			ld_level[ch] = 7'd0;
		end else if (code == CODE_ZERO) begin
			ld_level[ch] = 7'd0;
		end
	endfunction

	// advance the set-point state by one transaction and return its result
	function automatic setpoint_result_t step_setpoints(logic sample, logic [7:0] cmd,
			logic [9:0] adc0, logic [9:0] adc1);
		setpoint_result_t r;
		int ch;
		r = '0;
		ch = cmd[7];
		if (sample) begin
			r.upd = 1'b1;
			r.dac0 = drive_dac(0, adc0);
			r.dac1 = drive_dac(1, adc1);
			if ((ld_power[0] && ld_level[0] != 0) || (ld_power[1] && ld_level[1] != 0))
				n_power_drive++;
		end else if (cmd[6:0] == CODE_SYNC_ON) begin
			ld_sync = 1'b1;
		end else if (cmd[6:0] == CODE_SYNC_OFF) begin
			ld_sync = 1'b0;
		end else begin
			apply_code(ch, cmd[6:0]);
			if (ld_sync)
				apply_code(1 - ch, cmd[6:0]);
		end
		r.pm0 = ld_power[0];
		r.pm1 = ld_power[1];
		r.lvl0 = ld_level[0];
		r.lvl1 = ld_level[1];
		r.sync = ld_sync;
		return r;
	endfunction

	task automatic send_transaction(stim_row_t row);
		setpoint_result_t pred;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.sample;
		s_tdata <= {4'b0, row.adc1, row.adc0, row.cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = step_setpoints(row.sample, row.cmd, row.adc0, row.adc1);
		expected_q.push_back(row.typed ? row.want : pred);
		if (row.sample)
			n_sample++;
		else
			n_cmd++;
		@(negedge clk);
	endtask

	function automatic logic [9:0] pick_adc();
		case ($urandom_range(0, 9))
			0: return 10'd0;
			1: return 10'd1;
			2: return 10'd1023;
			default: return 10'($urandom_range(0, dclsc_pkg::ADC_MAX));
		endcase
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t row;
		int pick;
		row = '0;
		row.cmd = 8'($urandom);
		if ($urandom_range(0, 99) < 45) begin
			row.sample = 1'b1;
			row.adc0 = pick_adc();
			row.adc1 = pick_adc();
		end else begin
			row.adc0 = 10'($urandom);
			row.adc1 = 10'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				row.cmd[6:0] = 7'($urandom_range(1, STEPS - 1));
			else if (pick < 58)
				row.cmd[6:0] = CODE_POWER;
			else if (pick < 66)
				row.cmd[6:0] = CODE_CURRENT;
			else if (pick < 72)
				row.cmd[6:0] = CODE_ZERO;
			else if (pick < 80)
				row.cmd[6:0] = CODE_SYNC_ON;
			else if (pick < 88)
				row.cmd[6:0] = CODE_SYNC_OFF;
		end
		return row;
	endfunction

	// stall the result side in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		setpoint_result_t got;
		setpoint_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.upd  = m_tuser;
			got.dac0 = m_tdata[11:0];
			got.dac1 = m_tdata[23:12];
			got.pm0  = m_tdata[24];
			got.pm1  = m_tdata[25];
			got.lvl0 = m_tdata[32:26];
			got.lvl1 = m_tdata[39:33];
			got.sync = m_tdata[40];
			if (expected_q.size() == 0) begin
				report_error("result transaction with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (got.upd !== want.upd)
					report_error($sformatf("dac_update got %0d exp %0d", got.upd, want.upd));
				if (got.dac0 !== want.dac0)
					report_error($sformatf("dac_ch0 got %0d exp %0d", got.dac0, want.dac0));
				if (got.dac1 !== want.dac1)
					report_error($sformatf("dac_ch1 got %0d exp %0d", got.dac1, want.dac1));
				if (got.pm0 !== want.pm0)
					report_error($sformatf("power_mode_ch0 got %0d exp %0d", got.pm0, want.pm0));
				if (got.pm1 !== want.pm1)
					report_error($sformatf("power_mode_ch1 got %0d exp %0d", got.pm1, want.pm1));
				if (got.lvl0 !== want.lvl0)
					report_error($sformatf("level_ch0 got %0d exp %0d", got.lvl0, want.lvl0));
				if (got.lvl1 !== want.lvl1)
					report_error($sformatf("level_ch1 got %0d exp %0d", got.lvl1, want.lvl1));
				if (got.sync !== want.sync)
					report_error($sformatf("sync_on got %0d exp %0d", got.sync, want.sync));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		ld_power[0] = 1'b0;
		ld_power[1] = 1'b0;
		ld_level[0] = 7'd0;
		ld_level[1] = 7'd0;
		ld_sync = 1'b0;
		errors = 0;
		cycle_count = 0;
		n_cmd = 0;
		n_sample = 0;
		n_power_drive = 0;
		quiet = 1'b0;

		// sample, cmd, adc0, adc1, typed, {upd, dac0, dac1, pm0, pm1, lvl0, lvl1, sync}
		directed_rows = '{
			'{1, 8'h00, 0, 0, 1, '{1, 0, 0, 0, 0, 0, 0, 0}},
			'{1, 8'hff, 1023, 1023, 1, '{1, 0, 0, 0, 0, 0, 0, 0}},
			'{0, 8'd119, 0, 0, 1, '{0, 0, 0, 0, 0, 119, 0, 0}},
			'{1, 8'h00, 512, 0, 1, '{1, 4095, 0, 0, 0, 119, 0, 0}},
			'{0, SEL_CH1 | 8'd1, 0, 0, 0, '0},
			'{1, 8'h00, 300, 700, 0, '0},
			'{0, SEL_CH1 | {1'b0, CODE_POWER}, 0, 0, 1, '{0, 0, 0, 0, 1, 119, 0, 0}},
			'{1, 8'h00, 1023, 0, 1, '{1, 4095, 0, 0, 1, 119, 0, 0}},
			'{0, SEL_CH1 | 8'd119, 0, 0, 0, '0},
			'{1, 8'h00, 0, 0, 1, '{1, 4095, 4095, 0, 1, 119, 119, 0}},
			'{1, 8'h00, 5, 1, 1, '{1, 4095, 4095, 0, 1, 119, 119, 0}},
			'{1, 8'h00, 0, 1023, 0, '0},
			'{0, {1'b0, CODE_SYNC_ON}, 0, 0, 1, '{0, 0, 0, 0, 1, 119, 119, 1}},
			'{0, 8'd50, 0, 0, 0, '0},
			'{0, SEL_CH1 | {1'b0, CODE_CURRENT}, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 1}},
			'{0, {1'b0, CODE_SPARE0}, 0, 0, 0, '0},
			'{0, SEL_CH1 | {1'b0, CODE_SPARE2}, 0, 0, 0, '0},
			'{0, {1'b0, CODE_SPARE4}, 0, 0, 0, '0},
			'{0, SEL_CH1 | {1'b0, CODE_SPARE6}, 0, 0, 0, '0},
			'{0, {1'b0, CODE_POWER}, 0, 0, 1, '{0, 0, 0, 1, 1, 0, 0, 1}},
			'{0, SEL_CH1 | {1'b0, CODE_SYNC_OFF}, 0, 0, 1, '{0, 0, 0, 1, 1, 0, 0, 0}},
			'{0, 8'd70, 1023, 1023, 0, '0},
			'{1, 8'h00, 1023, 512, 0, '0},
			'{0, {1'b0, CODE_ZERO}, 0, 0, 1, '{0, 0, 0, 1, 1, 0, 0, 0}},
			'{1, 8'h00, 0, 1023, 1, '{1, 0, 0, 1, 1, 0, 0, 0}}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_transaction(directed_rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == QUIET_FROM)
				quiet = 1'b1;
			send_transaction(random_row());
		end
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d command and %0d sample transactions in %0d cycles.",
			n_cmd, n_sample, cycle_count);
		$display("Power-mode drive computed on %0d samples; %0d mismatches.",
			n_power_drive, errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== dual_channel_load_setpoint_controller_unit.f =====
sv/dclsc_pkg.sv
sv/dual_channel_load_setpoint_controller_unit.sv
tb/testbench.sv
